// ===== design/wsom_pkg.sv =====
// ----------------------------------------------------------------------------
// wsom_pkg
// Shared types and constants for the slot pool and display order manager.
// ----------------------------------------------------------------------------
`default_nettype none

package wsom_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_PROMOTE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot_id;
    logic [SLOT_W-1:0]   order_pos;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_out;
    logic [CNT_W-1:0]    used_total;
    logic [SLOT_W-1:0]   top_slot;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_APPEND,
    S_TOP_RD,
    S_TOP_LD,
    S_READ_LD,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_DISPATCH,
    CMD_SRCH_RD,
    CMD_SRCH_CMP,
    CMD_SHIFT_RD,
    CMD_SHIFT_WR,
    CMD_APPEND,
    CMD_TOP_RD,
    CMD_TOP_LD,
    CMD_READ_LD,
    CMD_OUT_LOAD
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    action_t act;
    logic    err;
    logic    hit;
    logic    more;
    logic    empty;
    logic    out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/wsom_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsom_ctrl
// Sequencer for one request: dispatch, order list search, shift and append,
// top refresh, read load and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wsom_ctrl
  import wsom_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  dp_stat_t      stat,
  output cmd_t          cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd = CMD_DISPATCH;
        if (stat.err) begin
          state_nxt = S_FINISH;
        end else begin
          case (stat.act)
            ACT_ALLOC:   state_nxt = S_FINISH;
            ACT_FREE:    state_nxt = S_SRCH_RD;
            ACT_PROMOTE: state_nxt = S_SRCH_RD;
            ACT_READ:    state_nxt = S_READ_LD;
            default:     state_nxt = S_FINISH;
          endcase
        end
      end
      S_SRCH_RD: begin
        cmd       = CMD_SRCH_RD;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd       = CMD_SRCH_CMP;
        state_nxt = stat.hit ? S_SHIFT : S_SRCH_RD;
      end
      S_SHIFT: begin
        if (stat.more) begin
          cmd       = CMD_SHIFT_RD;
          state_nxt = S_SHIFT_WR;
        end else if (stat.act == ACT_PROMOTE) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_TOP_RD;
        end
      end
      S_SHIFT_WR: begin
        cmd       = CMD_SHIFT_WR;
        state_nxt = S_SHIFT;
      end
      S_APPEND: begin
        cmd       = CMD_APPEND;
        state_nxt = S_FINISH;
      end
      S_TOP_RD: begin
        cmd       = CMD_TOP_RD;
        state_nxt = stat.empty ? S_FINISH : S_TOP_LD;
      end
      S_TOP_LD: begin
        cmd       = CMD_TOP_LD;
        state_nxt = S_FINISH;
      end
      S_READ_LD: begin
        cmd       = CMD_READ_LD;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd       = CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/wsom_dp.sv =====
// ----------------------------------------------------------------------------
// wsom_dp
// Free stack, in-use bits, order list memory, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsom_dp
  import wsom_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  cmd_t          cmd,
  input  in_item_t      in_data,
  output dp_stat_t      stat,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  in_item_t            req_r;
  logic [SLOT_W-1:0]   fs_r [SLOTS];
  logic [SLOTS-1:0]    fs_wr_r;
  logic [SLOTS-1:0]    fs_wr_nxt;
  logic [CNT_W-1:0]    free_total_r;
  logic [CNT_W-1:0]    free_total_nxt;
  logic [CNT_W-1:0]    order_total_r;
  logic [CNT_W-1:0]    order_total_nxt;
  logic [SLOTS-1:0]    in_use_r;
  logic [SLOTS-1:0]    in_use_nxt;
  logic [SLOT_W-1:0]   top_r;
  logic [SLOT_W-1:0]   top_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_r;
  logic [SLOT_W-1:0]   j_r;
  status_t             status_r;
  logic [SLOT_W-1:0]   res_r;

  logic [SLOT_W-1:0]   ol_mem [SLOTS];
  logic [SLOT_W-1:0]   rd_data_r;
  logic                mem_re;
  logic [SLOT_W-1:0]   mem_ra;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_wa;
  logic [SLOT_W-1:0]   mem_wd;

  logic [SLOT_W-1:0]   pop_idx;
  logic [SLOT_W-1:0]   push_idx;
  logic [SLOT_W-1:0]   pop_slot;
  logic [SLOT_W-1:0]   tail_idx;
  logic [SLOT_W-1:0]   last_idx;
  logic                err;
  status_t             err_code;

  assign pop_idx  = free_total_r[SLOT_W-1:0] - SLOT_W'(1);
  assign push_idx = free_total_r[SLOT_W-1:0];
  assign tail_idx = order_total_r[SLOT_W-1:0];
  assign last_idx = order_total_r[SLOT_W-1:0] - SLOT_W'(1);
  // entries never pushed are not written and read as their entry index
  assign pop_slot = fs_wr_r[pop_idx] ? fs_r[pop_idx] : pop_idx;

  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    case (req_r.action)
      ACT_ALLOC: begin
        err      = (free_total_r == '0);
        err_code = ST_FULL;
      end
      ACT_FREE, ACT_PROMOTE: begin
        err      = !in_use_r[req_r.slot_id];
        err_code = ST_NOT_USED;
      end
      ACT_READ: begin
        err      = ({1'b0, req_r.order_pos} >= order_total_r);
        err_code = ST_BEYOND;
      end
      default: begin
        err      = 1'b0;
        err_code = ST_OK;
      end
    endcase
  end

  assign stat.act      = req_r.action;
  assign stat.err      = err;
  assign stat.hit      = (rd_data_r == req_r.slot_id);
  assign stat.more     = ({1'b0, j_r} < order_total_r);
  assign stat.empty    = (order_total_r == '0);
  assign stat.out_busy = out_valid_r && !out_ready;

  // order list port selection
  always_comb begin
    mem_re = 1'b0;
    mem_ra = j_r;
    mem_we = 1'b0;
    mem_wa = tail_idx;
    mem_wd = req_r.slot_id;
    case (cmd)
      CMD_DISPATCH: begin
        if (!err && req_r.action == ACT_READ) begin
          mem_re = 1'b1;
          mem_ra = req_r.order_pos;
        end
        if (!err && req_r.action == ACT_ALLOC) begin
          mem_we = 1'b1;
          mem_wd = pop_slot;
        end
      end
      CMD_SRCH_RD: begin
        mem_re = 1'b1;
      end
      CMD_SHIFT_RD: begin
        mem_re = 1'b1;
        mem_ra = j_r + SLOT_W'(1);
      end
      CMD_SHIFT_WR: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        mem_wd = rd_data_r;
      end
      CMD_APPEND: begin
        mem_we = 1'b1;
      end
      CMD_TOP_RD: begin
        mem_re = !stat.empty;
        mem_ra = last_idx;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ol_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= ol_mem[mem_ra];
    end
  end

  // control state next values
  always_comb begin
    fs_wr_nxt       = fs_wr_r;
    free_total_nxt  = free_total_r;
    order_total_nxt = order_total_r;
    in_use_nxt      = in_use_r;
    top_nxt         = top_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    case (cmd)
      CMD_DISPATCH: begin
        if (!err && req_r.action == ACT_ALLOC) begin
          free_total_nxt            = free_total_r - CNT_W'(1);
          order_total_nxt           = order_total_r + CNT_W'(1);
          in_use_nxt[pop_slot]      = 1'b1;
          top_nxt                   = pop_slot;
        end
        if (!err && req_r.action == ACT_FREE) begin
          fs_wr_nxt[push_idx]       = 1'b1;
          free_total_nxt            = free_total_r + CNT_W'(1);
          in_use_nxt[req_r.slot_id] = 1'b0;
        end
      end
      CMD_SRCH_CMP: begin
        if (stat.hit) begin
          order_total_nxt = order_total_r - CNT_W'(1);
        end
      end
      CMD_APPEND: begin
        order_total_nxt = order_total_r + CNT_W'(1);
        top_nxt         = req_r.slot_id;
      end
      CMD_TOP_RD: begin
        if (stat.empty) begin
          top_nxt = '0;
        end
      end
      CMD_TOP_LD: begin
        top_nxt = rd_data_r;
      end
      CMD_OUT_LOAD: begin
        out_valid_nxt = 1'b1;
      end
      default: begin
        top_nxt = top_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_wr_r       <= '0;
      free_total_r  <= CNT_W'(SLOTS);
      order_total_r <= '0;
      in_use_r      <= '0;
      top_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      fs_wr_r       <= fs_wr_nxt;
      free_total_r  <= free_total_nxt;
      order_total_r <= order_total_nxt;
      in_use_r      <= in_use_nxt;
      top_r         <= top_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_CAPTURE: begin
        req_r <= in_data;
      end
      CMD_DISPATCH: begin
        j_r      <= '0;
        status_r <= err ? err_code : ST_OK;
        res_r    <= (req_r.action == ACT_ALLOC) ? pop_slot : '0;
        if (!err && req_r.action == ACT_FREE) begin
          fs_r[push_idx] <= req_r.slot_id;
        end
      end
      CMD_SRCH_CMP: begin
        if (!stat.hit) begin
          j_r <= j_r + SLOT_W'(1);
        end
      end
      CMD_SHIFT_WR: begin
        j_r <= j_r + SLOT_W'(1);
      end
      CMD_READ_LD: begin
        res_r <= rd_data_r;
      end
      CMD_OUT_LOAD: begin
        out_r.status     <= status_r;
        out_r.slot_out   <= (status_r == ST_OK) ? res_r : '0;
        out_r.used_total <= order_total_r;
        out_r.top_slot   <= top_r;
      end
      default: begin
        j_r <= j_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== design/window_slot_and_order_manager_unit.sv =====
// ----------------------------------------------------------------------------
// window_slot_and_order_manager_unit
// Slot pool with a free stack and a display order list: allocate, free,
// promote to top and read by order position, one result per request.
// ----------------------------------------------------------------------------
//  channel   ports                          direction   payload
//  in        in_valid / in_ready / in_data  input       in_item_t
//  out       out_valid / out_ready / out_data output    out_item_t
//
//  one request at a time; allocate and refused requests go from dispatch
//  to the result hand-off, read loads the addressed entry first. free and
//  promote walk the order list memory (one read, one write port): a read
//  and a compare per entry searched, a read and a write per entry shifted.
//  reset is immediate, no clearing pass; a waiting result stalls only the
//  final hand-off, the next request is accepted once it is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module window_slot_and_order_manager_unit
  import wsom_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  cmd_t     cmd;
  dp_stat_t stat;

  wsom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wsom_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.slot_out == '0))
    else $error("refused request carries a slot");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.used_total <= CNT_W'(SLOTS)))
    else $error("used count beyond pool size");

  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.used_total == CNT_W'(SLOTS)))
    else $error("pool full reported with free slots left");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.used_total == '0) |-> (out_data.top_slot == '0))
    else $error("top slot set with no slot in use");

endmodule

`default_nettype wire
